// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active low)
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/tsim_pkg.sv =====
// ----------------------------------------------------------------------------
// tsim_pkg
// Shared constants and types of the streaming Tanimoto similarity block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsim_pkg;

  // Field widths
  localparam int VAL_W     = 16;  // signed Q8.8 descriptor value
  localparam int SIM_W     = 17;  // unsigned Q1.16 similarity
  localparam int TOTAL_W   = 13;  // reported both-on count
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 32;

  // Defaults
  localparam int MAX_LENGTH_DEF  = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic signed [VAL_W-1:0] THRESHOLD_RESET = 16'sd128;  // 0.5

  // Queue status between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Divider sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsim_front.sv =====
// ----------------------------------------------------------------------------
// tsim_front
// Thresholds each value pair, keeps the three saturating counters and pushes
// the both-on and union counts into the queue on the last item of a vector.
// ----------------------------------------------------------------------------
`default_nettype none

module tsim_front import tsim_pkg::*; #(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF,
  parameter int CNT_W      = 13,
  parameter int UNI_W      = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // first_value[15:0], second_value[31:16]
  input  wire logic                  in_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [VAL_W-1:0]      cfg_data,
  input  wire q_stat_t               q_stat,
  output logic                       push,
  output logic [CNT_W-1:0]           push_both,
  output logic [UNI_W-1:0]           push_uni
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LENGTH);

  logic signed [VAL_W-1:0] thr_r;
  logic [CNT_W-1:0] both_r, sec_r, fst_r;
  logic [CNT_W-1:0] both_nxt, sec_nxt, fst_nxt;
  logic             accept;
  logic             a_on, b_on;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      thr_r <= $signed(cfg_data);
    end
  end

  // Classify the pair, saturating counts
  always_comb begin
    a_on     = $signed(in_tdata[VAL_W-1:0]) >= thr_r;
    b_on     = $signed(in_tdata[2*VAL_W-1:VAL_W]) >= thr_r;
    both_nxt = both_r;
    sec_nxt  = sec_r;
    fst_nxt  = fst_r;
    if (a_on && b_on) begin
      both_nxt = (both_r < CNT_MAX) ? both_r + 1'b1 : CNT_MAX;
    end else if (b_on) begin
      sec_nxt = (sec_r < CNT_MAX) ? sec_r + 1'b1 : CNT_MAX;
    end else if (a_on) begin
      fst_nxt = (fst_r < CNT_MAX) ? fst_r + 1'b1 : CNT_MAX;
    end
  end

  // Hand the totals to the back on the last item
  assign push      = accept && in_tlast;
  assign push_both = both_nxt;
  assign push_uni  = UNI_W'(both_nxt) + UNI_W'(sec_nxt) + UNI_W'(fst_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      both_r <= '0;
      sec_r  <= '0;
      fst_r  <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        both_r <= '0;
        sec_r  <= '0;
        fst_r  <= '0;
      end else begin
        both_r <= both_nxt;
        sec_r  <= sec_nxt;
        fst_r  <= fst_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tsim_fifo.sv =====
// ----------------------------------------------------------------------------
// tsim_fifo
// Short queue of finished vector totals between counting and division.
// ----------------------------------------------------------------------------
`default_nettype none

module tsim_fifo import tsim_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int W     = 28
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output q_stat_t           stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tsim_div.sv =====
// ----------------------------------------------------------------------------
// tsim_div
// Back end: restoring divider, one quotient bit per cycle, and the result
// register of the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tsim_div import tsim_pkg::*; #(
  parameter int CNT_W = 13,
  parameter int UNI_W = 15
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire q_stat_t                q_stat,
  input  wire logic [CNT_W-1:0]       q_both,
  input  wire logic [UNI_W-1:0]       q_uni,
  output logic                        pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_DATA_W-1:0]       out_tdata,  // similarity[16:0], both_on_total[29:17]
  output logic                        out_tuser   // empty_union
);

  localparam int STEP_W = $clog2(SIM_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SIM_W - 1);

  back_state_t        state_r, state_nxt;
  logic [UNI_W:0]     rem_r, rem_nxt;
  logic [UNI_W-1:0]   uni_r, uni_nxt;
  logic [SIM_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [TOTAL_W-1:0] both_r, both_nxt;
  logic               flag_r, flag_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;
  logic               ge;
  logic [UNI_W:0]     diff, rsel;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // One compare-subtract step
  assign ge   = rem_r >= {1'b0, uni_r};
  assign diff = rem_r - {1'b0, uni_r};
  assign rsel = ge ? diff : rem_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    uni_nxt       = uni_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    both_nxt      = both_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    pop           = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          rem_nxt  = (UNI_W+1)'(q_both);
          uni_nxt  = q_uni;
          quo_nxt  = '0;
          step_nxt = '0;
          if (q_uni == '0) begin
            both_nxt  = '0;
            flag_nxt  = 1'b1;
            state_nxt = BK_HOLD;
          end else begin
            both_nxt  = TOTAL_W'(q_both);
            flag_nxt  = 1'b0;
            state_nxt = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        quo_nxt = {quo_r[SIM_W-2:0], ge};
        // remainder stays below the divisor, so the shift cannot overflow
        rem_nxt = {rsel[UNI_W-1:0], 1'b0};
        if (step_r == STEP_LAST) begin
          state_nxt = BK_HOLD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      BK_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({both_r, quo_r});
          out_user_nxt  = flag_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    uni_r      <= uni_nxt;
    quo_r      <= quo_nxt;
    both_r     <= both_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tanimoto_similarity_stream.sv =====
// ----------------------------------------------------------------------------
// tanimoto_similarity_stream
// Binary Tanimoto similarity of two descriptor vectors streamed pairwise.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one value pair per item, in_tlast marks the final pair of a vector.
//           Items are taken one per cycle while the result queue has room.
//   out_* : one item per vector: Q1.16 similarity and both-on count in
//           out_tdata, empty-union flag in out_tuser.
//   cfg_* : threshold write (signed Q8.8), always ready; write only when idle.
// Result path: from the last item of a vector to its result through the
//   queue read, 17 divider steps and the result load.
// Throughput: counting runs at one item per cycle while the queue has room;
//   one vector at a time goes through the divider, so short vectors fill
//   the queue of QUEUE_DEPTH entries and in_tready drops until a slot frees up.
// Reset clears the counters, the queue and the result register and loads
//   the threshold with 0.5. A stalled receiver holds the result; the divider
//   waits with its next result until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module tanimoto_similarity_stream import tsim_pkg::*; #(
  parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // first_value[15:0], second_value[31:16]
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // similarity[16:0], both_on_total[29:17]
  output logic                       out_tuser,  // empty_union
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [VAL_W-1:0]      cfg_data
);

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int UNI_W = CNT_W + 2;
  localparam int Q_W   = CNT_W + UNI_W;

  q_stat_t          q_stat;
  logic             push, pop;
  logic [CNT_W-1:0] push_both;
  logic [UNI_W-1:0] push_uni;
  logic [Q_W-1:0]   q_rd;

  tsim_front #(
    .MAX_LENGTH (MAX_LENGTH),
    .CNT_W      (CNT_W),
    .UNI_W      (UNI_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_both (push_both),
    .push_uni  (push_uni)
  );

  tsim_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .W     (Q_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data ({push_uni, push_both}),
    .rd_en   (pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  tsim_div #(
    .CNT_W (CNT_W),
    .UNI_W (UNI_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_both     (q_rd[CNT_W-1:0]),
    .q_uni      (q_rd[Q_W-1:CNT_W]),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tsim_checker.sv =====
// ----------------------------------------------------------------------------
// tsim_checker
// Port-level checks of the similarity stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tsim_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [15:0] cfg_data
);

  // Empty union reports zero ratio and zero count
  `ASSERT_SYNC(a_empty_zero, clk, rst_n, (out_tvalid && out_tuser) |-> (out_tdata[29:0] == 30'd0))

  // Ratio never exceeds one
  `ASSERT_SYNC(a_sim_range, clk, rst_n, out_tvalid |-> (out_tdata[16:0] <= 17'd65536))

  // Reset empties the result register
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid)

  // Stalled result holds
  `ASSERT_SYNC(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))

endmodule

bind tanimoto_similarity_stream tsim_checker u_tsim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_data   (cfg_data)
);

`default_nettype wire

// ===== tb/sv/tb_tanimoto_similarity_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tanimoto_similarity_stream
// Self-checking bench for the streaming binary Tanimoto similarity block.
// Vector pairs are streamed under several thresholds, the extremes included.
// A bit-accurate score model in the bench predicts each result.
// Output items are compared field by field, in order, against that model.
// Both sides idle at random, except for one long stretch with no idling.
// ----------------------------------------------------------------------------

module tb_tanimoto_similarity_stream;
  import tsim_pkg::*;

  localparam int MAX_LEN     = MAX_LENGTH_DEF;
  localparam int STALL_LIMIT = 5000;   // cycles with no handshake at all
  localparam int DRAIN_WAIT  = 40;     // extra wait once every score has arrived

  typedef struct {
    logic signed [VAL_W-1:0] first_value;
    logic signed [VAL_W-1:0] second_value;
    logic                    last;
  } pair_t;

  typedef struct {
    logic [SIM_W-1:0]   similarity;
    logic [TOTAL_W-1:0] both_on_total;
    logic               empty_union;
  } score_t;

  // DUT signals
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // first_value[15:0], second_value[31:16]
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // similarity[16:0], both_on_total[29:17]
  logic                  out_tuser;       // empty_union
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [VAL_W-1:0]      cfg_data = '0;

  // Stimulus and scoreboard state
  pair_t  pair_q[$];
  score_t score_q[$];
  pair_t  next_pair;
  score_t want;
  bit     calm = 1'b0;
  int     queued_count = 0;
  int     accepted_count = 0;
  int     result_count = 0;
  int     fail_count = 0;
  int     thr_settings = 1;
  int     stall_cycles = 0;

  // Score model state
  logic signed [VAL_W-1:0] thr_model = THRESHOLD_RESET;
  int unsigned both_cnt = 0;
  int unsigned second_cnt = 0;
  int unsigned first_cnt = 0;

  tanimoto_similarity_stream u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Count one accepted pair; on the last pair queue the expected score
  task automatic score_pair(input logic signed [VAL_W-1:0] a,
                            input logic signed [VAL_W-1:0] b,
                            input logic last);
    bit a_on;
    bit b_on;
    longint unsigned uni;
    score_t s;
    a_on = (a >= thr_model);
    b_on = (b >= thr_model);
    if (a_on && b_on) begin
      if (both_cnt < MAX_LEN) both_cnt++;
    end else if (b_on) begin
      if (second_cnt < MAX_LEN) second_cnt++;
    end else if (a_on) begin
      if (first_cnt < MAX_LEN) first_cnt++;
    end
    if (last) begin
      uni = longint'(both_cnt) + second_cnt + first_cnt;
      if (uni == 0) begin
        s.similarity    = '0;
        s.both_on_total = '0;
        s.empty_union   = 1'b1;
      end else begin
        s.similarity    = SIM_W'((longint'(both_cnt) << 16) / uni);
        s.both_on_total = TOTAL_W'(both_cnt);
        s.empty_union   = 1'b0;
      end
      score_q.push_back(s);
      both_cnt   = 0;
      second_cnt = 0;
      first_cnt  = 0;
    end
  endtask

  // Input side and config monitor, feeds the score model
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) thr_model = cfg_data;
    if (rst_n && in_tvalid && in_tready) begin
      accepted_count++;
      score_pair(in_tdata[15:0], in_tdata[31:16], in_tlast);
    end
  end

  // Input driver: hold the item until taken, idle now and then
  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && !in_tready)) begin
      if (pair_q.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
        next_pair = pair_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {next_pair.second_value, next_pair.first_value};
        in_tlast  <= next_pair.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 7);

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ERROR: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Output monitor: compare with the oldest expected score
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (score_q.size() == 0) begin
        $display("%0t ERROR: unexpected result, expected none, got sim=%0d total=%0d empty=%0b",
                 $time, out_tdata[16:0], out_tdata[29:17], out_tuser);
        fail_count++;
      end else begin
        want = score_q.pop_front();
        result_count++;
        check_field("similarity", want.similarity, out_tdata[16:0]);
        check_field("both_on_total", want.both_on_total, out_tdata[29:17]);
        check_field("empty_union", want.empty_union, out_tuser);
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ERROR: no handshake for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, score_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --- stimulus helpers ---

  task automatic push_pair(input logic signed [VAL_W-1:0] a,
                           input logic signed [VAL_W-1:0] b,
                           input logic last);
    pair_t p;
    p.first_value  = a;
    p.second_value = b;
    p.last         = last;
    pair_q.push_back(p);
    queued_count++;
  endtask

  // Random value in [thr, max]
  function automatic logic signed [VAL_W-1:0] on_value(logic signed [VAL_W-1:0] thr);
    int lo;
    logic signed [VAL_W-1:0] v;
    lo = int'(thr);
    v = VAL_W'(int'($urandom_range(32767 - lo)) + lo);
    return v;
  endfunction

  // Random value in [min, thr-1]; thr must be above the minimum
  function automatic logic signed [VAL_W-1:0] off_value(logic signed [VAL_W-1:0] thr);
    int hi;
    logic signed [VAL_W-1:0] v;
    hi = int'(thr);
    v = VAL_W'(int'($urandom_range(hi - 1 + 32768)) - 32768);
    return v;
  endfunction

  // Mix of full-range values, threshold edges and field extremes
  function automatic logic signed [VAL_W-1:0] pick_value(logic signed [VAL_W-1:0] thr);
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = VAL_W'($urandom);
      3:       v = thr;
      4:       v = thr - 1;
      5:       v = thr + 1;
      6:       v = 16'sh8000;
      7:       v = 16'sh7fff;
      8:       v = on_value(thr);
      default: v = (thr == 16'sh8000) ? 16'($urandom) : off_value(thr);
    endcase
    return v;
  endfunction

  // Whole vectors of mostly short length until n_items are queued
  task automatic add_random_vectors(input int n_items, input logic signed [VAL_W-1:0] thr);
    int added;
    int len;
    int r;
    added = 0;
    while (added < n_items) begin
      r = $urandom_range(99);
      if (r < 85)      len = $urandom_range(12, 1);
      else if (r < 95) len = $urandom_range(40, 13);
      else             len = $urandom_range(100, 41);
      for (int i = 0; i < len; i++)
        push_pair(pick_value(thr), pick_value(thr), i == len - 1);
      added += len;
    end
  endtask

  // Wait until every item is taken and every score has arrived
  task automatic settle();
    while (accepted_count != queued_count || score_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_threshold(input logic signed [VAL_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_settings++;
    @(negedge clk);
  endtask

  // --- main sequence ---
  initial begin
    logic signed [VAL_W-1:0] rand_thr;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed at the reset threshold of 0.5
    push_pair(16'sd128, 16'sd128, 1'b1);            // single pair, both on
    push_pair(16'sd127, 16'sd127, 1'b1);            // empty union
    push_pair(16'sh8000, 16'sh7fff, 1'b0);          // second only
    push_pair(16'sh7fff, 16'sh8000, 1'b0);          // first only
    push_pair(16'sd127, 16'sd128, 1'b0);            // second only at the edge
    push_pair(16'sd0, 16'sd0, 1'b1);                // both off, no both-on at all
    push_pair(16'sh7fff, 16'sh7fff, 1'b0);
    push_pair(16'sd128, 16'sd127, 1'b0);
    push_pair(-16'sd1, -16'sd1, 1'b1);              // half similarity
    push_pair(16'sh7fff, 16'sh7fff, 1'b0);
    push_pair(16'sd200, 16'sd300, 1'b0);
    push_pair(16'sh8000, 16'sh8000, 1'b1);          // full similarity with an off pair
    push_pair(16'sd129, 16'sd129, 1'b0);
    push_pair(16'sd0, 16'sd129, 1'b0);
    push_pair(16'sd129, -16'sd129, 1'b1);           // one third
    push_pair(16'sh8000, 16'sh8000, 1'b1);          // empty union at the minimum
    settle();

    // Lowest threshold: every value is on
    write_threshold(16'sh8000);
    add_random_vectors(50, 16'sh8000);
    settle();

    // Highest threshold: only the maximum is on
    write_threshold(16'sh7fff);
    add_random_vectors(50, 16'sh7fff);
    settle();

    // Zero threshold, no idling
    write_threshold(16'sd0);
    calm = 1'b1;
    add_random_vectors(200, 16'sd0);
    settle();
    calm = 1'b0;

    rand_thr = VAL_W'($urandom);
    write_threshold(rand_thr);
    add_random_vectors(200, rand_thr);
    settle();

    write_threshold(THRESHOLD_RESET);
    add_random_vectors(100, THRESHOLD_RESET);
    settle();

    if (score_q.size() != 0) begin
      $display("%0t ERROR: %0d expected results never arrived", $time, score_q.size());
      fail_count++;
    end

    $display("Streamed %0d pairs, %0d vector scores checked, over %0d threshold settings,",
             accepted_count, result_count, thr_settings);
    $display("including threshold extremes, empty unions and a stretch without idling.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
